@@ hw/rtl/srs_pkg.sv @@
package srs_pkg;

	// Commands carried by the request channel.
	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2
	} command_t;

	// What the back end has to do with a queued transfer.
	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_LOAD    = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// Program word opcodes, bits 7..5 of a stored word.
	typedef enum logic [2:0] {
		OP_END     = 3'd0,
		OP_MOV     = 3'd1,
		OP_WAIT    = 3'd2,
		OP_LOOP    = 3'd3,
		OP_ENDLOOP = 3'd4,
		OP_DELAY   = 3'd5,
		OP_DMOV    = 3'd6,
		OP_NOP     = 3'd7
	} opcode_t;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MOVE   = 2'd1;
	localparam logic [1:0] ERR_NESTED = 2'd2;

	localparam logic [4:0] MOV_MAX  = 5'd5;
	localparam logic [4:0] DMOV_MAX = 5'd3;

	localparam logic signed [7:0] LOOP_FLOOR = 8'sh80;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0] command;
		logic       channel;
		logic       running;
		logic [4:0] load_address;
		logic [2:0] load_opcode;
		logic [4:0] load_argument;
	} request_t;

	typedef struct packed {
		logic       result_channel;
		logic       move_valid;
		logic [2:0] move_position;
		logic [4:0] current_pc;
		logic       finished;
		logic [1:0] error_code;
		logic [4:0] wait_left;
	} result_t;

	// Classified transfer as it sits in the queue between front and back.
	typedef struct packed {
		kind_t      kind;
		logic       channel;
		logic       running;
		logic [4:0] address;
		logic [7:0] word;
	} entry_t;

endpackage

@@ hw/rtl/srs_if.sv @@
interface srs_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/servo_recipe_sequencer_core.sv @@
// Path: request -> queue -> execute stage -> result register, which offers the result.
// Throughput: one transfer per cycle on any mix of commands and channels while the
// consumer takes results; the program store read for a tick is issued as the item
// enters execute, with the pc forwarded from the item ahead, so the store (one read
// and one write a cycle) and the state update set the pace.
// Reset: arst_n clears all channel state, the queue and the result valid flag at once;
// the program store is not cleared and holds whatever was loaded.
module servo_recipe_sequencer_core
	import srs_pkg::*;
#(
	parameter int PROGRAM_DEPTH = 32,
	parameter int CHANNELS = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	srs_if.sink   request,
	srs_if.source status
);

	// The front end only classifies: it folds out-of-range channels onto channel 0
	// and turns loads past the store depth and unknown commands into status-only
	// transfers. It is purely combinational.
	srs_if #(.T(entry_t)) front_q ();

	// The queue between front and back lets the requester keep transferring while
	// the result register waits on the consumer.
	srs_if #(.T(entry_t)) queue_b ();

	srs_front #(
		.PROGRAM_DEPTH(PROGRAM_DEPTH),
		.CHANNELS(CHANNELS)
	) u_front (
		.request(request),
		.queue(front_q)
	);

	srs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_q),
		.pop(queue_b)
	);

	// The back end owns the program store and per-channel state. Every transfer
	// produces exactly one status result, in order.
	srs_back #(
		.PROGRAM_DEPTH(PROGRAM_DEPTH),
		.CHANNELS(CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(queue_b),
		.status(status)
	);

endmodule

@@ hw/rtl/srs_front.sv @@
module srs_front
	import srs_pkg::*;
#(
	parameter int PROGRAM_DEPTH = 32,
	parameter int CHANNELS = 2
) (
	srs_if.sink   request,
	srs_if.source queue
);

	request_t req;
	logic     chan_ok;
	logic     addr_ok;
	entry_t   entry;

	assign req = request.payload;

	// Channels beyond the configured count fall back to channel 0; loads beyond
	// the store depth do nothing and are passed on as status-only transfers.
	assign chan_ok = 4'(req.channel) < 4'(CHANNELS);
	assign addr_ok = 9'(req.load_address) < 9'(PROGRAM_DEPTH);

	always_comb begin
		entry.channel = chan_ok ? req.channel : 1'b0;
		entry.running = req.running;
		entry.address = req.load_address;
		entry.word    = {req.load_opcode, req.load_argument};
		unique case (req.command)
			CMD_TICK:    entry.kind = KIND_TICK;
			CMD_LOAD:    entry.kind = addr_ok ? KIND_LOAD : KIND_NONE;
			CMD_RESTART: entry.kind = KIND_RESTART;
			default:     entry.kind = KIND_NONE;
		endcase
	end

	assign queue.valid   = request.valid;
	assign queue.payload = entry;
	assign request.ready = queue.ready;

endmodule

@@ hw/rtl/srs_queue.sv @@
module srs_queue
	import srs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	srs_if.sink   push,
	srs_if.source pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	entry_t           entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push.ready  = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop.valid   = count_q != '0;
	assign pop.payload = entries_q[rd_ptr_q];

	assign do_push = push.valid && push.ready;
	assign do_pop  = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/srs_back.sv @@
module srs_back
	import srs_pkg::*;
#(
	parameter int PROGRAM_DEPTH = 32,
	parameter int CHANNELS = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	srs_if.sink   head,
	srs_if.source status
);

	localparam int PC_W      = $clog2(PROGRAM_DEPTH);
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * PROGRAM_DEPTH;
	localparam int MEM_W     = $clog2(MEM_DEPTH);
	localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROGRAM_DEPTH - 1);

	// Program store, one region of PROGRAM_DEPTH words per channel.
	logic [7:0]       mem_q [MEM_DEPTH];

	// Per-channel sequencing state.
	logic [PC_W-1:0]  pc_q    [CHANNELS];
	logic [4:0]       wait_q  [CHANNELS];
	logic [4:0]       delay_q [CHANNELS];
	logic signed [7:0] loop_q [CHANNELS];
	logic [PC_W-1:0]  ret_q   [CHANNELS];
	logic             end_q   [CHANNELS];
	logic [1:0]       err_q   [CHANNELS];

	// Execute stage.
	logic             e_v_s1;
	entry_t           e_s1;
	logic [PC_W-1:0]  pc_s1;
	logic [7:0]       rd_s1;
	logic             byp_s1;
	logic [7:0]       byp_word_s1;

	// Result register.
	logic             out_v_q;
	result_t          result_s2;

	logic [CH_W-1:0]  e_ch;
	logic [CH_W-1:0]  h_ch;
	logic             e_adv;
	logic             do_pop;
	logic [7:0]       word;
	opcode_t          op;
	logic [4:0]       arg;
	logic             exec;
	logic [PC_W-1:0]  step_pc;
	logic [PC_W-1:0]  nx_pc;
	logic [4:0]       nx_wait;
	logic [4:0]       nx_delay;
	logic signed [7:0] nx_loop;
	logic [PC_W-1:0]  nx_ret;
	logic             nx_end;
	logic [1:0]       nx_err;
	logic             mv;
	logic [2:0]       mpos;
	logic [PC_W-1:0]  pc_fwd;
	logic [MEM_W-1:0] rd_idx;
	logic [MEM_W-1:0] wr_idx;
	logic             wr_en;

	assign e_ch = CH_W'(e_s1.channel);
	assign h_ch = CH_W'(head.payload.channel);

	assign e_adv      = e_v_s1 && (!out_v_q || status.ready);
	assign head.ready = !e_v_s1 || e_adv;
	assign do_pop     = head.valid && head.ready;

	assign word = byp_s1 ? byp_word_s1 : rd_s1;
	assign op   = opcode_t'(word[7:5]);
	assign arg  = word[4:0];

	always_comb begin
		exec     = 1'b0;
		mv       = 1'b0;
		mpos     = '0;
		step_pc  = pc_s1;
		nx_pc    = pc_s1;
		nx_wait  = wait_q[e_ch];
		nx_delay = delay_q[e_ch];
		nx_loop  = loop_q[e_ch];
		nx_ret   = ret_q[e_ch];
		nx_end   = end_q[e_ch];
		nx_err   = err_q[e_ch];
		unique case (e_s1.kind)
			KIND_TICK: begin
				exec = e_s1.running && (wait_q[e_ch] == '0) && (err_q[e_ch] == ERR_NONE);
				if (exec) begin
					unique case (op)
						OP_MOV: begin
							if (arg > MOV_MAX) begin
								nx_err = ERR_MOVE;
							end else begin
								mv   = 1'b1;
								mpos = arg[2:0];
							end
						end
						OP_DMOV: begin
							if (arg > DMOV_MAX) begin
								nx_err = ERR_MOVE;
							end else begin
								mv   = 1'b1;
								mpos = {arg[1:0], 1'b0};
							end
						end
						OP_DELAY: nx_delay = arg;
						// The wait count is zero whenever an instruction runs.
						OP_WAIT:  nx_wait = arg;
						OP_LOOP: begin
							if (loop_q[e_ch] != 8'sd0) begin
								nx_err = ERR_NESTED;
							end
							nx_loop = 8'(arg);
							nx_ret  = pc_s1;
						end
						OP_ENDLOOP: begin
							if (loop_q[e_ch] != LOOP_FLOOR) begin
								nx_loop = loop_q[e_ch] - 8'sd1;
							end
							if (nx_loop > 8'sd0) begin
								step_pc = ret_q[e_ch];
							end
						end
						OP_END:   nx_end = 1'b1;
						OP_NOP:   ;
					endcase
					if (nx_end) begin
						nx_pc = step_pc;
					end else begin
						nx_pc = (step_pc == PC_LAST) ? '0 : step_pc + 1'b1;
					end
				end
				nx_wait = (nx_wait == '0) ? nx_delay : nx_wait - 1'b1;
			end
			KIND_RESTART: begin
				nx_pc    = '0;
				nx_wait  = '0;
				nx_delay = '0;
				nx_loop  = '0;
				nx_ret   = '0;
				nx_end   = 1'b0;
				nx_err   = ERR_NONE;
			end
			KIND_LOAD, KIND_NONE: ;
		endcase
	end

	// The next item's word is fetched at the edge where it enters execute, so a
	// same-channel item still in execute hands its new pc straight over.
	assign pc_fwd = (e_v_s1 && (e_ch == h_ch)) ? nx_pc : pc_q[h_ch];
	assign rd_idx = MEM_W'(h_ch) * MEM_W'(PROGRAM_DEPTH) + MEM_W'(pc_fwd);
	assign wr_idx = MEM_W'(e_ch) * MEM_W'(PROGRAM_DEPTH) + MEM_W'(PC_W'(e_s1.address));
	assign wr_en  = e_adv && (e_s1.kind == KIND_LOAD);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= e_s1.word;
		end
		if (do_pop) begin
			rd_s1 <= mem_q[rd_idx];
		end
	end

	// A load leaving execute writes the word the entering item may read.
	always_ff @(posedge clk) begin
		if (do_pop) begin
			e_s1        <= head.payload;
			pc_s1       <= pc_fwd;
			byp_s1      <= wr_en && (wr_idx == rd_idx);
			byp_word_s1 <= e_s1.word;
		end
		if (e_adv) begin
			result_s2.result_channel <= e_s1.channel;
			result_s2.move_valid     <= mv;
			result_s2.move_position  <= mpos;
			result_s2.current_pc     <= 5'(nx_pc);
			result_s2.finished       <= nx_end;
			result_s2.error_code     <= nx_err;
			result_s2.wait_left      <= nx_wait;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v_s1  <= 1'b0;
			out_v_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				pc_q[c]    <= '0;
				wait_q[c]  <= '0;
				delay_q[c] <= '0;
				loop_q[c]  <= '0;
				ret_q[c]   <= '0;
				end_q[c]   <= 1'b0;
				err_q[c]   <= ERR_NONE;
			end
		end else begin
			if (head.ready) begin
				e_v_s1 <= head.valid;
			end
			if (e_adv) begin
				out_v_q       <= 1'b1;
				pc_q[e_ch]    <= nx_pc;
				wait_q[e_ch]  <= nx_wait;
				delay_q[e_ch] <= nx_delay;
				loop_q[e_ch]  <= nx_loop;
				ret_q[e_ch]   <= nx_ret;
				end_q[e_ch]   <= nx_end;
				err_q[e_ch]   <= nx_err;
			end else if (status.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign status.valid   = out_v_q;
	assign status.payload = result_s2;

`ifndef SYNTHESIS
	a_pc_forward: assert property (@(posedge clk) disable iff (!arst_n)
		e_v_s1 |-> pc_s1 == pc_q[e_ch])
		else $error("execute pc differs from committed channel pc");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		e_v_s1 && !e_adv |=> e_v_s1 && $stable(e_s1) && $stable(pc_s1))
		else $error("stalled execute stage changed");

	a_move_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (result_s2.move_valid && result_s2.move_position != 3'd7)
			|| (!result_s2.move_valid && result_s2.move_position == 3'd0))
		else $error("move position out of range");

	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		e_adv && e_s1.kind == KIND_RESTART |=> status.valid
			&& status.payload.current_pc == 5'd0 && !status.payload.finished
			&& status.payload.error_code == ERR_NONE && status.payload.wait_left == 5'd0)
		else $error("restart left channel state behind");
`endif

endmodule
